>>> src/tsa_pkg.sv
// ----------------------------------------------------------------------------
// tsa_pkg
// Shared widths, constants, the coefficient table and the item type of the
// truncated tanh series pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tsa_pkg;

    // Build-time configuration
    localparam int MAX_TERMS    = 11;
    localparam int FRAC_BITS    = 28;

    // Fixed number formats
    localparam int GUARD_BITS   = 4;
    localparam int COEF_BITS    = 62;
    localparam int CAP_LOG2     = 58;
    localparam int TABLE_TERMS  = 15;
    localparam int NUM_SECTIONS = MAX_TERMS - 1;

    localparam int ANGLE_W = 32;
    localparam int CNT_W   = 4;
    localparam int MAG_W   = 32;                  // |x| reaches 2^31
    localparam int P_W     = CAP_LOG2 + 1;        // power never exceeds the cap
    localparam int COEF_W  = COEF_BITS + 1;       // first coefficient is 2^62
    localparam int ACC_W   = P_W + 2;
    localparam int RMAG_W  = ACC_W - GUARD_BITS + 1;

    // Partial-product split of the wide multiplications
    localparam int P_LO_W  = 32;
    localparam int P_HI_W  = P_W - P_LO_W;
    localparam int C_LO_W  = 32;
    localparam int C_HI_W  = COEF_W - C_LO_W;
    localparam int PWR_W   = P_W + MAG_W + 1;
    localparam int SUM_W   = P_LO_W + MAG_W + P_HI_W + 1;
    localparam int TPROD_W = COEF_W + P_W + 1;

    localparam logic [CNT_W-1:0]   TERM_COUNT_RESET = 4'd11;
    localparam logic [P_W-1:0]     POWER_CAP        = {1'b1, {(P_W - 1){1'b0}}};
    localparam logic [ANGLE_W-1:0] OUT_MAX          = 32'h7FFF_FFFF;
    localparam logic [ANGLE_W-1:0] OUT_MIN          = 32'h8000_0000;

    typedef logic [0:TABLE_TERMS-1][63:0]       t_u64_tab;
    typedef logic [0:TABLE_TERMS-1][COEF_W-1:0] t_coef_tab;

    // |c_n| = num / (top * 10^18 + bottom)
    localparam logic [63:0] DEC18 = 64'd1000000000000000000;

    localparam t_u64_tab NUM_TAB = '{
        64'd1, 64'd1, 64'd2, 64'd17, 64'd62, 64'd1382, 64'd21844, 64'd929569,
        64'd6404582, 64'd443861162, 64'd18888466084, 64'd113927491862,
        64'd58870668456604, 64'd8374643517010684, 64'd689005380505609448};

    localparam t_u64_tab DEN_TOP = '{
        64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0,
        64'd0, 64'd0, 64'd0, 64'd0, 64'd3, 64'd1298, 64'd263505};

    localparam t_u64_tab DEN_BOT = '{
        64'd1, 64'd3, 64'd15, 64'd315, 64'd2835, 64'd155925, 64'd6081075,
        64'd638512875, 64'd10854718875, 64'd1856156927625,
        64'd194896477400625, 64'd2900518163668125, 64'd698160658676859375,
        64'd54391195577640625, 64'd41412702261046875};

    // Coefficient magnitudes in Q62, rounded half up. Evaluated once at
    // elaboration by restoring long division.
    function automatic t_coef_tab build_coef_tab();
        t_coef_tab    tab;
        logic [127:0] den;
        logic [127:0] rem;
        logic [63:0]  quo;
        tab    = '0;
        tab[0] = COEF_W'(1) << COEF_BITS;
        for (int n = 1; n < TABLE_TERMS; n++) begin
            den = 128'(DEN_TOP[n]) * 128'(DEC18) + 128'(DEN_BOT[n]);
            rem = 128'(NUM_TAB[n]);
            quo = '0;
            for (int i = 0; i < COEF_BITS + 1; i++) begin
                rem = rem << 1;
                quo = quo << 1;
                if (rem >= den) begin
                    rem    = rem - den;
                    quo[0] = 1'b1;
                end
            end
            tab[n] = COEF_W'((quo + 64'd1) >> 1);
        end
        return tab;
    endfunction

    localparam t_coef_tab COEF_TAB = build_coef_tab();

    // One item as it travels down the term sections
    typedef struct packed {
        logic [MAG_W-1:0]        a;
        logic                    neg;
        logic [P_W-1:0]          p;
        logic signed [ACC_W-1:0] acc;
        logic                    huge;
    } t_item;

endpackage

>>> src/tsa_term_section.sv
// ----------------------------------------------------------------------------
// tsa_term_section
// Four-stage section that adds one series term, if in use, to the running
// sum and raises the power by two further factors of |x| for the next section.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsa_term_section (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [tsa_pkg::CNT_W-1:0]  i_term_idx,
    input  logic [tsa_pkg::CNT_W-1:0]  i_nterms,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  tsa_pkg::t_item             i_item,
    output logic                       o_valid,
    input  logic                       i_ready,
    output tsa_pkg::t_item             o_item
);

    // Rounds p * a to the power format; the top bit flags an overflow
    function automatic logic [tsa_pkg::P_W:0] power_round(
        input logic [tsa_pkg::P_LO_W+tsa_pkg::MAG_W-1:0] lo,
        input logic [tsa_pkg::P_HI_W+tsa_pkg::MAG_W-1:0] hi
    );
        logic [tsa_pkg::PWR_W-1:0] w;
        logic [tsa_pkg::PWR_W-1:0] sh;
        logic                      ovf;
        w   = tsa_pkg::PWR_W'(lo) + (tsa_pkg::PWR_W'(hi) << tsa_pkg::P_LO_W)
              + (tsa_pkg::PWR_W'(1) << (tsa_pkg::FRAC_BITS - 1));
        sh  = w >> tsa_pkg::FRAC_BITS;
        ovf = sh > tsa_pkg::PWR_W'(tsa_pkg::POWER_CAP);
        return {ovf, ovf ? tsa_pkg::POWER_CAP : sh[tsa_pkg::P_W-1:0]};
    endfunction

    logic [3:0] r_v;
    logic [3:0] w_rdy;

    logic [tsa_pkg::COEF_W-1:0] w_coef;
    logic                       w_in_use;
    logic                       w_next_use;

    // Stage 1: partial products
    logic [tsa_pkg::MAG_W-1:0]               r1_a;
    logic                                    r1_neg;
    logic signed [tsa_pkg::ACC_W-1:0]        r1_acc;
    logic                                    r1_huge;
    logic [tsa_pkg::P_LO_W+tsa_pkg::MAG_W-1:0] r1_pl;
    logic [tsa_pkg::P_HI_W+tsa_pkg::MAG_W-1:0] r1_ph;
    logic [tsa_pkg::C_LO_W+tsa_pkg::P_LO_W-1:0] r1_tll;
    logic [tsa_pkg::C_LO_W+tsa_pkg::P_HI_W-1:0] r1_tlh;
    logic [tsa_pkg::C_HI_W+tsa_pkg::P_LO_W-1:0] r1_thl;
    logic [tsa_pkg::C_HI_W+tsa_pkg::P_HI_W-1:0] r1_thh;

    // Stage 2: first power rounded, term partial sums
    logic [tsa_pkg::MAG_W-1:0]        r2_a;
    logic                             r2_neg;
    logic signed [tsa_pkg::ACC_W-1:0] r2_acc;
    logic                             r2_huge;
    logic                             r2_ovf;
    logic [tsa_pkg::P_W-1:0]          r2_p;
    logic [tsa_pkg::SUM_W-1:0]        r2_sa;
    logic [tsa_pkg::SUM_W-1:0]        r2_sb;
    logic [tsa_pkg::P_W:0]            w_pr1;

    // Stage 3: second power products, rounded term
    logic [tsa_pkg::MAG_W-1:0]               r3_a;
    logic                                    r3_neg;
    logic signed [tsa_pkg::ACC_W-1:0]        r3_acc;
    logic                                    r3_huge;
    logic                                    r3_ovf;
    logic [tsa_pkg::P_LO_W+tsa_pkg::MAG_W-1:0] r3_pl;
    logic [tsa_pkg::P_HI_W+tsa_pkg::MAG_W-1:0] r3_ph;
    logic [tsa_pkg::P_W-1:0]                 r3_term;
    logic [tsa_pkg::TPROD_W-1:0]             w_tprod;

    // Stage 4: accumulate and finish the power
    tsa_pkg::t_item                   r4_item;
    logic [tsa_pkg::P_W:0]            w_pr2;
    logic signed [tsa_pkg::ACC_W-1:0] n_acc;
    logic                             n_huge;

    assign w_coef     = tsa_pkg::COEF_TAB[i_term_idx - 4'd1];
    assign w_in_use   = i_term_idx <= i_nterms;
    assign w_next_use = i_term_idx < i_nterms;

    // A stage takes new data when it is empty or its contents move on.
    always_comb begin
        w_rdy[3] = !r_v[3] || i_ready;
        w_rdy[2] = !r_v[2] || w_rdy[3];
        w_rdy[1] = !r_v[1] || w_rdy[2];
        w_rdy[0] = !r_v[0] || w_rdy[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) r_v[0] <= i_valid;
            if (w_rdy[1]) r_v[1] <= r_v[0];
            if (w_rdy[2]) r_v[2] <= r_v[1];
            if (w_rdy[3]) r_v[3] <= r_v[2];
        end
    end

    always_comb begin
        w_pr1   = power_round(r1_pl, r1_ph);
        w_tprod = tsa_pkg::TPROD_W'(r2_sa) + (tsa_pkg::TPROD_W'(r2_sb) << tsa_pkg::C_LO_W)
                  + (tsa_pkg::TPROD_W'(1) << (tsa_pkg::COEF_BITS - 1));
        w_pr2   = power_round(r3_pl, r3_ph);

        // Terms beyond the threshold leave the sum alone; odd terms add.
        n_acc = r3_acc;
        if (w_in_use) begin
            if (i_term_idx[0]) begin
                n_acc = r3_acc + $signed({2'b00, r3_term});
            end else begin
                n_acc = r3_acc - $signed({2'b00, r3_term});
            end
        end

        // An overflowing power only matters if the next term is in use.
        n_huge = r3_huge || ((r3_ovf || w_pr2[tsa_pkg::P_W]) && w_next_use);
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r1_a    <= i_item.a;
            r1_neg  <= i_item.neg;
            r1_acc  <= i_item.acc;
            r1_huge <= i_item.huge;
            r1_pl   <= i_item.p[tsa_pkg::P_LO_W-1:0] * i_item.a;
            r1_ph   <= i_item.p[tsa_pkg::P_W-1:tsa_pkg::P_LO_W] * i_item.a;
            r1_tll  <= w_coef[tsa_pkg::C_LO_W-1:0] * i_item.p[tsa_pkg::P_LO_W-1:0];
            r1_tlh  <= w_coef[tsa_pkg::C_LO_W-1:0] * i_item.p[tsa_pkg::P_W-1:tsa_pkg::P_LO_W];
            r1_thl  <= w_coef[tsa_pkg::COEF_W-1:tsa_pkg::C_LO_W]
                       * i_item.p[tsa_pkg::P_LO_W-1:0];
            r1_thh  <= w_coef[tsa_pkg::COEF_W-1:tsa_pkg::C_LO_W]
                       * i_item.p[tsa_pkg::P_W-1:tsa_pkg::P_LO_W];
        end
        if (w_rdy[1]) begin
            r2_a    <= r1_a;
            r2_neg  <= r1_neg;
            r2_acc  <= r1_acc;
            r2_huge <= r1_huge;
            r2_ovf  <= w_pr1[tsa_pkg::P_W];
            r2_p    <= w_pr1[tsa_pkg::P_W-1:0];
            r2_sa   <= tsa_pkg::SUM_W'(r1_tll) + (tsa_pkg::SUM_W'(r1_tlh) << tsa_pkg::P_LO_W);
            r2_sb   <= tsa_pkg::SUM_W'(r1_thl) + (tsa_pkg::SUM_W'(r1_thh) << tsa_pkg::P_LO_W);
        end
        if (w_rdy[2]) begin
            r3_a    <= r2_a;
            r3_neg  <= r2_neg;
            r3_acc  <= r2_acc;
            r3_huge <= r2_huge;
            r3_ovf  <= r2_ovf;
            r3_pl   <= r2_p[tsa_pkg::P_LO_W-1:0] * r2_a;
            r3_ph   <= r2_p[tsa_pkg::P_W-1:tsa_pkg::P_LO_W] * r2_a;
            r3_term <= w_tprod[tsa_pkg::COEF_BITS +: tsa_pkg::P_W];
        end
        if (w_rdy[3]) begin
            r4_item.a    <= r3_a;
            r4_item.neg  <= r3_neg;
            r4_item.p    <= w_pr2[tsa_pkg::P_W-1:0];
            r4_item.acc  <= n_acc;
            r4_item.huge <= n_huge;
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[3];
    assign o_item  = r4_item;

    a_power_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[3] |-> (r4_item.p <= tsa_pkg::POWER_CAP))
        else $error("power passed on beyond the cap");

endmodule

>>> src/tsa_output_stage.sv
// ----------------------------------------------------------------------------
// tsa_output_stage
// Rounds the guarded sum to the result format, saturates it, applies the
// sign of the angle and holds the result item for the consumer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsa_output_stage (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [tsa_pkg::CNT_W-1:0]   i_nterms,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  tsa_pkg::t_item              i_item,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [tsa_pkg::ANGLE_W-1:0] o_value
);

    logic                         w_rdy_a;
    logic                         w_rdy_b;
    logic [tsa_pkg::ACC_W-1:0]    w_abs;
    logic [tsa_pkg::ACC_W:0]      w_rnd;
    logic                         w_pos;

    logic                         r_a_v;
    logic [tsa_pkg::RMAG_W-1:0]   r_a_mag;
    logic                         r_a_pos;
    logic                         r_a_huge;

    logic                         r_b_v;
    logic [tsa_pkg::ANGLE_W-1:0]  r_b_value;
    logic [tsa_pkg::ANGLE_W-1:0]  n_b_value;
    logic [tsa_pkg::ANGLE_W-1:0]  w_mag32;

    assign w_rdy_b = !r_b_v || i_ready;
    assign w_rdy_a = !r_a_v || w_rdy_b;

    always_comb begin
        w_abs = i_item.acc[tsa_pkg::ACC_W-1] ? (~$unsigned(i_item.acc) + 1'b1)
                                             : $unsigned(i_item.acc);
        w_rnd = {1'b0, w_abs} + (tsa_pkg::ACC_W+1)'(1 << (tsa_pkg::GUARD_BITS - 1));
        // With a runaway power the result follows the sign of the last term.
        if (i_item.huge) begin
            w_pos = i_nterms[0] != i_item.neg;
        end else begin
            w_pos = !i_item.acc[tsa_pkg::ACC_W-1] != i_item.neg;
        end
    end

    always_comb begin
        w_mag32 = r_a_mag[tsa_pkg::ANGLE_W-1:0];
        if (r_a_huge) begin
            w_mag32 = r_a_pos ? tsa_pkg::OUT_MAX : tsa_pkg::OUT_MIN;
        end else if (r_a_pos && r_a_mag > tsa_pkg::RMAG_W'(tsa_pkg::OUT_MAX)) begin
            w_mag32 = tsa_pkg::OUT_MAX;
        end else if (!r_a_pos && r_a_mag > tsa_pkg::RMAG_W'(tsa_pkg::OUT_MIN)) begin
            w_mag32 = tsa_pkg::OUT_MIN;
        end
        n_b_value = r_a_pos ? w_mag32 : (~w_mag32 + 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
        end else begin
            if (w_rdy_a) r_a_v <= i_valid;
            if (w_rdy_b) r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_a) begin
            r_a_mag  <= w_rnd[tsa_pkg::ACC_W:tsa_pkg::GUARD_BITS];
            r_a_pos  <= w_pos;
            r_a_huge <= i_item.huge;
        end
        if (w_rdy_b) begin
            r_b_value <= n_b_value;
        end
    end

    assign o_ready = w_rdy_a;
    assign o_valid = r_b_v;
    assign o_value = r_b_value;

    a_huge_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_v && w_rdy_b && r_a_huge)
        |=> (r_b_value == tsa_pkg::OUT_MAX || r_b_value == tsa_pkg::OUT_MIN))
        else $error("runaway series did not give a saturated result");

    a_zero_stays_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_v && w_rdy_b && !r_a_huge && r_a_mag == '0) |=> (r_b_value == '0))
        else $error("zero magnitude gave a non-zero result");

endmodule

>>> src/tanh_series_approximation_core.sv
// ----------------------------------------------------------------------------
// tanh_series_approximation_core
// Truncated Maclaurin series of tanh on a signed Q4.28 angle, giving a
// saturated Q4.28 result. The core takes one angle per clock cycle unless a
// waiting result backs up the chain; it passes through the input register,
// the term sections and the output stage. Each term of the series owns a
// four-stage section, and that depth is set by the two multiply-and-round
// steps that raise the power by x squared between one term and the next.
// Stalls on the output side are absorbed by empty stages, so angles are
// still taken while a result waits. The term count register may be written
// only while no item is in flight; values above MAX_TERMS act as MAX_TERMS
// and a count of one or zero gives zero. Past pi/2 the series diverges and is
// returned as computed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tanh_series_approximation_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [tsa_pkg::ANGLE_W-1:0] i_angle,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [tsa_pkg::ANGLE_W-1:0] o_tanh_value,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tsa_pkg::CNT_W-1:0]         i_cfg_term_count
);

    logic [tsa_pkg::CNT_W-1:0] r_term_count;
    logic [tsa_pkg::CNT_W:0]   w_count;
    logic [tsa_pkg::CNT_W-1:0] w_nterms;

    logic                      r_in_v;
    tsa_pkg::t_item            r_in_item;
    tsa_pkg::t_item            n_in_item;
    logic                      w_in_rdy;

    logic                      w_sv [0:tsa_pkg::NUM_SECTIONS];
    logic                      w_sr [0:tsa_pkg::NUM_SECTIONS];
    tsa_pkg::t_item            w_si [0:tsa_pkg::NUM_SECTIONS];

    logic [tsa_pkg::ANGLE_W-1:0] w_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_count <= tsa_pkg::TERM_COUNT_RESET;
        end else if (i_cfg_valid) begin
            r_term_count <= i_cfg_term_count;
        end
    end

    assign o_cfg_ready = 1'b1;

    // Number of terms summed: the count, clipped to MAX_TERMS, less one.
    always_comb begin
        w_count = ({1'b0, r_term_count} > (tsa_pkg::CNT_W+1)'(tsa_pkg::MAX_TERMS))
                  ? (tsa_pkg::CNT_W+1)'(tsa_pkg::MAX_TERMS) : {1'b0, r_term_count};
        w_nterms = (w_count == '0) ? '0 : tsa_pkg::CNT_W'(w_count - 1'b1);
    end

    // Input stage: magnitude of the angle and the first power |x| * 16.
    always_comb begin
        n_in_item.neg  = i_angle[tsa_pkg::ANGLE_W-1];
        n_in_item.a    = n_in_item.neg ? (~$unsigned(i_angle) + 1'b1) : $unsigned(i_angle);
        n_in_item.p    = tsa_pkg::P_W'({n_in_item.a, {tsa_pkg::GUARD_BITS{1'b0}}});
        n_in_item.acc  = '0;
        n_in_item.huge = 1'b0;
    end

    assign w_in_rdy = !r_in_v || w_sr[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (w_in_rdy) begin
            r_in_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_rdy) begin
            r_in_item <= n_in_item;
        end
    end

    assign o_in_ready = w_in_rdy;
    assign w_sv[0]    = r_in_v;
    assign w_si[0]    = r_in_item;

    for (genvar g = 0; g < tsa_pkg::NUM_SECTIONS; g++) begin : g_term
        tsa_term_section u_section (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_term_idx (tsa_pkg::CNT_W'(g + 1)),
            .i_nterms   (w_nterms),
            .i_valid    (w_sv[g]),
            .o_ready    (w_sr[g]),
            .i_item     (w_si[g]),
            .o_valid    (w_sv[g+1]),
            .i_ready    (w_sr[g+1]),
            .o_item     (w_si[g+1])
        );
    end

    tsa_output_stage u_output (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_nterms (w_nterms),
        .i_valid  (w_sv[tsa_pkg::NUM_SECTIONS]),
        .o_ready  (w_sr[tsa_pkg::NUM_SECTIONS]),
        .i_item   (w_si[tsa_pkg::NUM_SECTIONS]),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_value  (w_value)
    );

    assign o_tanh_value = $signed(w_value);

    // A ready consumer, or an empty output register, frees the whole chain.
    a_ready_follows_consumer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> o_in_ready)
        else $error("input stalled although the consumer takes items");

    a_ready_when_output_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled although no result is waiting");

endmodule
